// ===== src/can_burst_reassembler_assert.svh =====
// assertion macros for the can burst reassembler
`ifndef CAN_BURST_REASSEMBLER_ASSERT_SVH
`define CAN_BURST_REASSEMBLER_ASSERT_SVH

// property that holds at every clock edge out of reset
`define CBR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define CBR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== src/cbr_pkg.sv =====
// shared types and constants of the can burst reassembler
package cbr_pkg;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned GAP_W     = 8;
  localparam int unsigned FRAMES_W  = 6;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FRAMES_W-1:0] FRAME_CAP  = 6'd32;
  localparam logic [FRAMES_W-1:0] SLOT_KEEP0 = 6'd2;
  localparam logic [FRAMES_W-1:0] SLOT_KEEP1 = 6'd3;

  localparam logic [ID_W-1:0]     MATCH_ID_RST   = 29'h100;
  localparam logic [GAP_W-1:0]    GAP_MS_RST     = 8'd5;
  localparam logic [FRAMES_W-1:0] MIN_FRAMES_RST = 6'd20;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES = 2'd2;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [TIME_W-1:0] time_ms;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_push_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

endpackage

// ===== src/cbr_front.sv =====
// front stage: takes frames, drops foreign identifiers, feeds the queue
module cbr_front import cbr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ID_W-1:0]   can_id_i,
  input  logic [DATA_W-1:0] payload_i,
  input  logic [TIME_W-1:0] time_ms_i,
  input  logic [ID_W-1:0]   match_id_i,
  input  q_status_t         q_status_i,
  output q_push_t           q_push_o
);

  logic   valid_q, valid_d;
  frame_t frame_q;
  logic   accept;
  logic   push;

  assign push       = valid_q && !q_status_i.full;
  assign in_stall_o = valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (push) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = (can_id_i == match_id_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q.payload <= payload_i;
      frame_q.time_ms <= time_ms_i;
    end
  end

  assign q_push_o.valid = push;
  assign q_push_o.frame = frame_q;

endmodule

// ===== src/cbr_queue.sv =====
// short queue of matching frames between front and back
module cbr_queue import cbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_push_t   push_i,
  input  logic      pop_i,
  output frame_t    head_o,
  output q_status_t status_o
);

  frame_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               full, empty, do_push, do_pop;

  assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = push_i.valid && !full;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = full;
  assign status_o.empty = empty;
  assign status_o.count = count_q;

endmodule

// ===== src/cbr_back.sv =====
// back stage: burst tracking, payload capture and result register
module cbr_back import cbr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frame_t              head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  input  logic [GAP_W-1:0]    gap_ms_i,
  input  logic [FRAMES_W-1:0] min_frames_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [WORD_W-1:0] engine_speed_o,
  output logic signed [WORD_W-1:0] manifold_pressure_o,
  output logic signed [WORD_W-1:0] coolant_temp_o,
  output logic signed [WORD_W-1:0] intake_temp_o,
  output logic signed [WORD_W-1:0] throttle_pos_o,
  output logic [COUNT_W-1:0]  record_count_o
);

  logic [FRAMES_W-1:0] frames_q, frames_d, frames_base;
  logic [TIME_W-1:0]   last_q, last_d, delta;
  logic [DATA_W-1:0]   keep0_q, keep0_d;
  logic [WORD_W-1:0]   keep1_q, keep1_d;
  logic [COUNT_W-1:0]  records_q, records_d;
  logic                out_valid_q, out_valid_d;
  logic                close, emit, out_free, pop;
  logic [5*WORD_W-1:0] words_q;
  logic [COUNT_W-1:0]  count_q;

  assign delta    = head_i.time_ms - last_q;
  assign close    = (delta > TIME_W'(gap_ms_i));
  assign emit     = close && (frames_q >= min_frames_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = head_valid_i && (!emit || out_free);
  assign frames_base = close ? '0 : frames_q;

  always_comb begin
    frames_d    = frames_q;
    last_d      = last_q;
    keep0_d     = keep0_q;
    keep1_d     = keep1_q;
    records_d   = records_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop) begin
      last_d = head_i.time_ms;
      if (emit) begin
        records_d   = records_q + 1'b1;
        out_valid_d = 1'b1;
      end
      frames_d = frames_base;
      if (frames_base < FRAME_CAP) begin
        if (frames_base == SLOT_KEEP0) begin
          keep0_d = head_i.payload;
        end else if (frames_base == SLOT_KEEP1) begin
          keep1_d = head_i.payload[DATA_W-1 -: WORD_W];
        end
        frames_d = frames_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= '0;
      last_q      <= '0;
      keep0_q     <= '0;
      keep1_q     <= '0;
      records_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      frames_q    <= frames_d;
      last_q      <= last_d;
      keep0_q     <= keep0_d;
      keep1_q     <= keep1_d;
      records_q   <= records_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      words_q <= {keep0_q, keep1_q};
      count_q <= records_q + 1'b1;
    end
  end

  assign pop_o               = pop;
  assign out_valid_o         = out_valid_q;
  assign engine_speed_o      = signed'(words_q[5*WORD_W-1 -: WORD_W]);
  assign manifold_pressure_o = signed'(words_q[4*WORD_W-1 -: WORD_W]);
  assign coolant_temp_o      = signed'(words_q[3*WORD_W-1 -: WORD_W]);
  assign intake_temp_o       = signed'(words_q[2*WORD_W-1 -: WORD_W]);
  assign throttle_pos_o      = signed'(words_q[WORD_W-1:0]);
  assign record_count_o      = count_q;

endmodule

// ===== src/can_burst_reassembler.sv =====
// top level of the can burst reassembler
// Usage:
// Input channel: in_valid_i / in_stall_o with can_id_i, payload_i, time_ms_i.
// A request is taken at a clock edge with in_valid_i high and in_stall_o low.
// Frames whose identifier differs from match_id are dropped at the front stage.
// Output channel: out_valid_o / out_stall_i with five signed words and the
// record count; a result is delivered at an edge with out_valid_o high and
// out_stall_i low, and holds steady while stalled.
// Config: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high, unknown indexes are ignored. Write only while the block is idle.
// Throughput: one frame per cycle, set by the burst update in the back stage,
// while no closing frame waits on a stalled output. Path: a closing frame that
// is taken passes front register, queue write, then result register.
// Out stalled: the back stage keeps taking frames that produce no result; a
// frame that would produce one waits, the two-entry queue fills, then the
// front register holds and in_stall_o rises.
// Reset: burst state, counts and config return to defaults; the output words,
// output count and stored frames are not reset. No clearing pass is needed.
module can_burst_reassembler import cbr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ID_W-1:0]      can_id_i,
  input  logic [DATA_W-1:0]    payload_i,
  input  logic [TIME_W-1:0]    time_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [WORD_W-1:0] engine_speed_o,
  output logic signed [WORD_W-1:0] manifold_pressure_o,
  output logic signed [WORD_W-1:0] coolant_temp_o,
  output logic signed [WORD_W-1:0] intake_temp_o,
  output logic signed [WORD_W-1:0] throttle_pos_o,
  output logic [COUNT_W-1:0]   record_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ID_W-1:0]      cfg_data_i
);

  `include "can_burst_reassembler_assert.svh"

  logic [ID_W-1:0]     match_id_q;
  logic [GAP_W-1:0]    gap_ms_q;
  logic [FRAMES_W-1:0] min_frames_q;
  q_push_t             q_push;
  q_status_t           q_status;
  frame_t              q_head;
  logic                q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q   <= MATCH_ID_RST;
      gap_ms_q     <= GAP_MS_RST;
      min_frames_q <= MIN_FRAMES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MATCH_ID:   match_id_q   <= cfg_data_i;
        REG_GAP_MS:     gap_ms_q     <= cfg_data_i[GAP_W-1:0];
        REG_MIN_FRAMES: min_frames_q <= cfg_data_i[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  cbr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .can_id_i   (can_id_i),
    .payload_i  (payload_i),
    .time_ms_i  (time_ms_i),
    .match_id_i (match_id_q),
    .q_status_i (q_status),
    .q_push_o   (q_push)
  );

  cbr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  cbr_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (q_head),
    .head_valid_i        (!q_status.empty),
    .pop_o               (q_pop),
    .gap_ms_i            (gap_ms_q),
    .min_frames_i        (min_frames_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .engine_speed_o      (engine_speed_o),
    .manifold_pressure_o (manifold_pressure_o),
    .coolant_temp_o      (coolant_temp_o),
    .intake_temp_o       (intake_temp_o),
    .throttle_pos_o      (throttle_pos_o),
    .record_count_o      (record_count_o)
  );

  `CBR_ASSERT(a_queue_bound, q_status.count <= Q_CNT_W'(Q_DEPTH))
  `CBR_ASSERT(a_no_push_full, !(q_push.valid && q_status.full))
  `CBR_ASSERT(a_no_pop_empty, !(q_pop && q_status.empty))
  `CBR_ASSERT_NEXT(a_stall_needs_full, in_stall_o, q_status.count != '0)

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the can burst reassembler with its own burst predictor
module tb;
  import cbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD    = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    logic [TIME_W-1:0] stamp;
  } can_frame_t;

  typedef struct {
    logic signed [WORD_W-1:0] engine_speed;
    logic signed [WORD_W-1:0] manifold_pressure;
    logic signed [WORD_W-1:0] coolant_temp;
    logic signed [WORD_W-1:0] intake_temp;
    logic signed [WORD_W-1:0] throttle_pos;
    logic [COUNT_W-1:0]       record_count;
  } gauge_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ID_W-1:0]      can_id = '0;
  logic [DATA_W-1:0]    payload = '0;
  logic [TIME_W-1:0]    time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [WORD_W-1:0] engine_speed;
  logic signed [WORD_W-1:0] manifold_pressure;
  logic signed [WORD_W-1:0] coolant_temp;
  logic signed [WORD_W-1:0] intake_temp;
  logic signed [WORD_W-1:0] throttle_pos;
  logic [COUNT_W-1:0]   record_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ID_W-1:0]      cfg_data = '0;

  // predictor copy of registers and burst state
  logic [ID_W-1:0]      cfg_match = MATCH_ID_RST;
  logic [GAP_W-1:0]     cfg_gap = GAP_MS_RST;
  logic [FRAMES_W-1:0]  cfg_min = MIN_FRAMES_RST;
  logic [FRAMES_W-1:0]  burst_frames = '0;
  logic [TIME_W-1:0]    last_stamp = '0;
  logic [DATA_W-1:0]    kept_lo = '0;
  logic [DATA_W-1:0]    kept_hi = '0;
  logic [COUNT_W-1:0]   records = '0;

  can_frame_t frame_queue[$];
  gauge_rec_t pending_records[$];

  logic [TIME_W-1:0] gen_time = '0;
  int items_queued = 0;
  int items_taken = 0;
  int frames_ignored = 0;
  int records_checked = 0;
  int settings_used = 1;
  int errors = 0;
  int idle_pct = 0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int gap_left = 0;

  always #1 clk = ~clk;

  can_burst_reassembler u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .can_id_i            (can_id),
    .payload_i           (payload),
    .time_ms_i           (time_ms),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .engine_speed_o      (engine_speed),
    .manifold_pressure_o (manifold_pressure),
    .coolant_temp_o      (coolant_temp),
    .intake_temp_o       (intake_temp),
    .throttle_pos_o      (throttle_pos),
    .record_count_o      (record_count),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  task automatic update_burst(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] data,
                              input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] dt;
    gauge_rec_t rec;
    if (id != cfg_match) begin
      frames_ignored++;
      return;
    end
    dt = now - last_stamp;
    if (dt > TIME_W'(cfg_gap)) begin
      if (burst_frames >= cfg_min) begin
        records = records + 1'b1;
        rec.engine_speed      = kept_lo[63:48];
        rec.manifold_pressure = kept_lo[47:32];
        rec.coolant_temp      = kept_lo[31:16];
        rec.intake_temp       = kept_lo[15:0];
        rec.throttle_pos      = kept_hi[63:48];
        rec.record_count      = records;
        pending_records.push_back(rec);
      end
      burst_frames = '0;
    end
    last_stamp = now;
    if (burst_frames < FRAME_CAP) begin
      if (burst_frames == SLOT_KEEP0) kept_lo = data;
      else if (burst_frames == SLOT_KEEP1) kept_hi = data;
      burst_frames = burst_frames + 1'b1;
    end
  endtask

  task automatic check_word(input string what, input logic [COUNT_W-1:0] want,
                            input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns %s expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin : drv
    can_frame_t f;
    logic nv;
    if (rst_n) begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        update_burst(can_id, payload, time_ms);
        items_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 4);
        end else if (frame_queue.size() != 0) begin
          f = frame_queue.pop_front();
          can_id  <= f.id;
          payload <= f.data;
          time_ms <= f.stamp;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin : mon
    gauge_rec_t rec;
    logic ns;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_records.size() == 0) begin
          $display("%0t ns unexpected result expected none actual record_count %h",
                   $time, record_count);
          errors++;
        end else begin
          rec = pending_records.pop_front();
          check_word("engine_speed", COUNT_W'($unsigned(rec.engine_speed)),
                     COUNT_W'($unsigned(engine_speed)));
          check_word("manifold_pressure", COUNT_W'($unsigned(rec.manifold_pressure)),
                     COUNT_W'($unsigned(manifold_pressure)));
          check_word("coolant_temp", COUNT_W'($unsigned(rec.coolant_temp)),
                     COUNT_W'($unsigned(coolant_temp)));
          check_word("intake_temp", COUNT_W'($unsigned(rec.intake_temp)),
                     COUNT_W'($unsigned(intake_temp)));
          check_word("throttle_pos", COUNT_W'($unsigned(rec.throttle_pos)),
                     COUNT_W'($unsigned(throttle_pos)));
          check_word("record_count", rec.record_count, record_count);
          records_checked++;
        end
      end
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 4);
        ns = 1'b1;
      end else begin
        ns = 1'b0;
      end
      out_stall <= ns;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MATCH_ID:   cfg_match = data;
      REG_GAP_MS:     cfg_gap = data[GAP_W-1:0];
      REG_MIN_FRAMES: cfg_min = data[FRAMES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [ID_W-1:0] mid, input logic [GAP_W-1:0] gap,
                            input logic [FRAMES_W-1:0] minf);
    logic [ID_W-1:0] junk;
    junk = ID_W'($urandom);
    write_reg(REG_MATCH_ID, mid);
    write_reg(REG_GAP_MS, {junk[ID_W-1:GAP_W], gap});
    write_reg(REG_MIN_FRAMES, {junk[ID_W-1:FRAMES_W], minf});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_frame(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] data,
                            input logic [TIME_W-1:0] stamp);
    can_frame_t f;
    f.id = id;
    f.data = data;
    f.stamp = stamp;
    frame_queue.push_back(f);
    items_queued++;
  endtask

  task automatic push_match(input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] dt);
    gen_time = gen_time + dt;
    push_frame(cfg_match, data, gen_time);
  endtask

  function automatic logic [DATA_W-1:0] rand_payload();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ID_W-1:0] stray_id();
    logic [ID_W-1:0] flip;
    if ($urandom_range(0, 1)) flip = ID_W'(1) << $urandom_range(0, ID_W - 1);
    else flip = ID_W'($urandom);
    if (flip == '0) flip = ID_W'(1);
    return cfg_match ^ flip;
  endfunction

  task automatic gen_burst(input int len);
    logic [TIME_W-1:0] dt;
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        if ($urandom_range(0, 3) == 0) dt = $urandom;
        else dt = cfg_gap + $urandom_range(1, 20);
        if (dt <= TIME_W'(cfg_gap)) dt = cfg_gap + 1;
      end else if ($urandom_range(0, 99) < 4) begin
        dt = $urandom;
      end else begin
        dt = $urandom_range(0, cfg_gap);
      end
      push_match(rand_payload(), dt);
      if ($urandom_range(0, 99) < 12) push_frame(stray_id(), rand_payload(), $urandom);
    end
  endtask

  task automatic run_phase(input int budget);
    int used;
    int len;
    used = 0;
    while (used < budget) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 3);
        1: len = $urandom_range(30, 40);
        default: begin
          len = cfg_min + $urandom_range(0, 6);
          len = len - 2;
        end
      endcase
      if (len < 1) len = 1;
      gen_burst(len);
      used += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first frame against zero time, equal gap, extreme words
    idle_pct = 20;
    push_match('1, 32'd2);
    push_frame('1, '0, '1);
    push_frame('0, '1, '0);
    push_frame(MATCH_ID_RST ^ 29'h1, rand_payload(), $urandom);
    for (int k = 1; k <= 20; k++) begin
      case (k % 4)
        0: push_match(k == 2 ? 64'h8000_7FFF_FFFF_0001 : rand_payload(),
                      TIME_W'(GAP_MS_RST));
        1: push_match(k == 3 ? 64'h7FFF_8000_0000_FFFF : rand_payload(), 32'd0);
        2: push_match(k == 2 ? 64'h8000_7FFF_FFFF_0001 : rand_payload(), 32'd1);
        default: push_match(k == 3 ? 64'h7FFF_8000_0000_FFFF : rand_payload(), 32'd3);
      endcase
    end
    push_match(rand_payload(), TIME_W'(GAP_MS_RST) + 32'd1);
    wait_drained();

    // short bursts decoded from stale slots, zero gap, wrapped time
    write_reg(REG_UNUSED, ID_W'($urandom));
    set_config(MATCH_ID_RST, 8'd0, 6'd0);
    push_match(rand_payload(), 32'd1);
    push_match(rand_payload(), 32'd0);
    push_match(rand_payload(), 32'hFFFF_FFFF);
    wait_drained();

    set_config(MATCH_ID_RST, GAP_MS_RST, MIN_FRAMES_RST);
    run_phase(250);
    wait_drained();

    idle_pct = 30;
    set_config('0, 8'd0, 6'd0);
    run_phase(200);
    wait_drained();

    idle_pct = 10;
    set_config('1, 8'hFF, FRAME_CAP);
    run_phase(250);
    wait_drained();

    idle_pct = 20;
    set_config(ID_W'($urandom), GAP_W'($urandom), 6'd40);
    run_phase(80);
    wait_drained();

    // output held off long while frames keep coming, then input pauses
    idle_pct = 5;
    set_config(ID_W'($urandom), 8'd0, 6'd1);
    hold_tag++;
    run_phase(150);
    wait_drained();
    run_phase(100);
    wait_drained();

    idle_pct = 25;
    repeat (2) begin
      set_config(ID_W'($urandom), GAP_W'($urandom_range(0, 255)),
                 FRAMES_W'($urandom_range(0, 32)));
      run_phase(250);
      wait_drained();
    end

    idle_pct = 0;
    set_config(ID_W'($urandom), GAP_W'($urandom_range(0, 40)),
               FRAMES_W'($urandom_range(0, 12)));
    run_phase(200);
    wait_drained();

    $display("frames sent %0d, of them %0d for other identifiers, under %0d settings",
             items_taken, frames_ignored, settings_used);
    $display("decoded bursts checked %0d, including a long output hold", records_checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
